@@ hw/rtl/vcpp_pkg.sv @@
// Package for the VPN control packet parser: payload types, event codes,
// field select codes and header layout constants. Depends on nothing.

package vcpp_pkg;

  localparam int POS_W         = 17;
  localparam int HDR_W         = 11;
  localparam int MIN_LENGTH    = 14;
  localparam int KEY_BITS      = 3;
  localparam int KEY_MASK      = 'h07;
  localparam int SESSION_BYTES = 8;
  localparam int ID_BYTES      = 4;
  localparam int LOCAL_START   = 3;
  localparam int ACK_COUNT_POS = LOCAL_START + SESSION_BYTES;
  localparam int ACKS_BASE     = ACK_COUNT_POS + 1;

  typedef enum logic [2:0] {
    EV_HEADER   = 3'd0,
    EV_ACK_DONE = 3'd1,
    EV_HDR_DONE = 3'd2,
    EV_PAYLOAD  = 3'd3,
    EV_REJECT   = 3'd4,
    EV_SKIP     = 3'd5,
    EV_TRUNC    = 3'd6
  } event_t;

  typedef enum logic [3:0] {
    FLD_NONE,
    FLD_LEN_HI,
    FLD_LEN_LO,
    FLD_OPKEY,
    FLD_LOCAL,
    FLD_ACK_COUNT,
    FLD_ACK,
    FLD_REMOTE,
    FLD_MSG_ID
  } field_sel_t;

  typedef struct packed {
    event_t     ev;
    logic       last;
    field_sel_t sel;
    logic       reject;
  } vcpp_ctl_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } vcpp_in_t;

  typedef struct packed {
    event_t      event_res;
    logic [15:0] packet_length;
    logic [4:0]  opcode;
    logic [2:0]  key_id;
    logic [63:0] local_session_id;
    logic [7:0]  ack_count;
    logic [31:0] ack_id;
    logic [63:0] remote_session_id;
    logic [31:0] message_packet_id;
    logic [7:0]  payload_byte;
    logic        last;
  } vcpp_out_t;

endpackage

@@ hw/rtl/vcpp_in_if.sv @@
// Input channel of the packet parser: valid, ready and one input word.
// Depends on vcpp_pkg.

interface vcpp_in_if import vcpp_pkg::*; ();
  logic     valid;
  logic     ready;
  vcpp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/vcpp_out_if.sv @@
// Result channel of the packet parser: valid, ready and one result word.
// Depends on vcpp_pkg.

interface vcpp_out_if import vcpp_pkg::*; ();
  logic      valid;
  logic      ready;
  vcpp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/vcpp_decode.sv @@
// Position decoder: maps the byte position, the header registers and the input byte to the
// event, end-of-packet flag, reject flag and field to update. Depends on vcpp_pkg.

module vcpp_decode import vcpp_pkg::*; (
  input  logic [POS_W-1:0] pos,
  input  logic [15:0]      length_reg,
  input  logic [7:0]       ack_count_reg,
  input  logic             rejected_flag,
  input  logic [7:0]       data_byte,
  output vcpp_ctl_t        ctl
);

  logic [15:0]      len_lo;
  logic [HDR_W-1:0] acks_end;
  logic [HDR_W-1:0] remote_end;
  logic [HDR_W-1:0] hdr_end;
  logic [POS_W-1:0] acks_end_x;
  logic [POS_W-1:0] remote_end_x;
  logic [POS_W-1:0] hdr_end_x;
  logic [POS_W-1:0] end_pos;

  assign len_lo       = {length_reg[15:8], data_byte};
  assign acks_end     = HDR_W'(ACKS_BASE) + {1'b0, ack_count_reg, 2'b00};
  assign remote_end   = acks_end + ((ack_count_reg != 8'd0) ? HDR_W'(SESSION_BYTES) : '0);
  assign hdr_end      = remote_end + HDR_W'(ID_BYTES);
  assign acks_end_x   = POS_W'(acks_end);
  assign remote_end_x = POS_W'(remote_end);
  assign hdr_end_x    = POS_W'(hdr_end);
  assign end_pos      = {1'b0, length_reg} + POS_W'(1);

  always_comb begin
    ctl.ev     = EV_HEADER;
    ctl.last   = 1'b0;
    ctl.sel    = FLD_NONE;
    ctl.reject = 1'b0;
    if (pos == '0) begin
      ctl.sel = FLD_LEN_HI;
    end else if (pos == POS_W'(1)) begin
      ctl.sel  = FLD_LEN_LO;
      ctl.last = (len_lo == 16'd0);
      if (len_lo < 16'(MIN_LENGTH)) begin
        ctl.reject = 1'b1;
        ctl.ev     = EV_REJECT;
      end
    end else begin
      ctl.last = (pos == end_pos);
      if (rejected_flag) begin
        ctl.ev = EV_SKIP;
      end else begin
        priority if (pos == POS_W'(2)) begin
          ctl.sel = FLD_OPKEY;
        end else if (pos < POS_W'(ACK_COUNT_POS)) begin
          ctl.sel = FLD_LOCAL;
        end else if (pos == POS_W'(ACK_COUNT_POS)) begin
          ctl.sel = FLD_ACK_COUNT;
        end else if (pos < acks_end_x) begin
          ctl.sel = FLD_ACK;
          if (pos[1:0] == 2'b11) begin
            ctl.ev = EV_ACK_DONE;
          end
        end else if (pos < remote_end_x) begin
          ctl.sel = FLD_REMOTE;
        end else if (pos < hdr_end_x) begin
          ctl.sel = FLD_MSG_ID;
          if (pos == hdr_end_x - POS_W'(1)) begin
            ctl.ev = EV_HDR_DONE;
          end
        end else begin
          ctl.ev = EV_PAYLOAD;
        end
        if (ctl.last && (pos + POS_W'(1) < hdr_end_x)) begin
          ctl.ev = EV_TRUNC;
        end
      end
    end
  end

endmodule

@@ hw/rtl/vpn_control_packet_parser_unit.sv @@
// Top level of the VPN control packet parser: field registers, byte position
// and the result register. Depends on vcpp_pkg, vcpp_in_if, vcpp_out_if, vcpp_decode.
//
//   channel   role    word         contents
//   bytes     sink    vcpp_in_t    one stream byte and the restart flag
//   events    source  vcpp_out_t   event code, header fields, payload byte, last
//
// Every byte yields one result word, registered in the cycle after it is accepted.
// A new byte is accepted every cycle unless a stalled result fills the result register.
// Reset clears the byte position, the rejected flag and the result valid flag.
// A stalled result blocks input only while the result register is full.

module vpn_control_packet_parser_unit import vcpp_pkg::*; (
  input logic        clk,
  input logic        rst,
  vcpp_in_if.sink    bytes,
  vcpp_out_if.source events
);

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] pos;
  logic [15:0]      length_reg;
  logic [4:0]       opcode_reg;
  logic [2:0]       key_reg;
  logic [63:0]      local_session_reg;
  logic [7:0]       ack_count_reg;
  logic [31:0]      ack_shift_reg;
  logic [63:0]      remote_session_reg;
  logic [31:0]      message_id_reg;
  logic             rejected_flag;
  logic             out_valid;
  event_t           event_reg;
  logic [7:0]       payload_reg;
  logic             last_reg;
  logic             accept;
  logic [7:0]       b;
  vcpp_ctl_t        ctl;

  assign b      = bytes.data.data_byte;
  assign pos    = bytes.data.restart ? '0 : byte_position;
  assign accept = bytes.valid && bytes.ready;

  assign bytes.ready = !out_valid || events.ready;

  vcpp_decode u_decode (
    .pos           (pos),
    .length_reg    (length_reg),
    .ack_count_reg (ack_count_reg),
    .rejected_flag (rejected_flag),
    .data_byte     (b),
    .ctl           (ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      rejected_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        out_valid     <= 1'b1;
        byte_position <= ctl.last ? '0 : pos + POS_W'(1);
        if (ctl.sel == FLD_LEN_HI) begin
          rejected_flag <= 1'b0;
        end else if (ctl.sel == FLD_LEN_LO) begin
          rejected_flag <= ctl.reject;
        end
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_reg   <= ctl.ev;
      last_reg    <= ctl.last;
      payload_reg <= (ctl.ev == EV_PAYLOAD) ? b : 8'd0;
      unique case (ctl.sel)
        FLD_LEN_HI: begin
          length_reg         <= {b, 8'd0};
          opcode_reg         <= '0;
          key_reg            <= '0;
          local_session_reg  <= '0;
          ack_count_reg      <= '0;
          ack_shift_reg      <= '0;
          remote_session_reg <= '0;
          message_id_reg     <= '0;
        end
        FLD_LEN_LO:    length_reg         <= {length_reg[15:8], b};
        FLD_OPKEY: begin
          opcode_reg <= b[7:KEY_BITS];
          key_reg    <= b[KEY_BITS-1:0] & 3'(KEY_MASK);
        end
        FLD_LOCAL:     local_session_reg  <= {local_session_reg[55:0], b};
        FLD_ACK_COUNT: ack_count_reg      <= b;
        FLD_ACK:       ack_shift_reg      <= {ack_shift_reg[23:0], b};
        FLD_REMOTE:    remote_session_reg <= {remote_session_reg[55:0], b};
        FLD_MSG_ID:    message_id_reg     <= {message_id_reg[23:0], b};
        default: begin
        end
      endcase
    end
  end

  assign events.valid                  = out_valid;
  assign events.data.event_res         = event_reg;
  assign events.data.packet_length     = length_reg;
  assign events.data.opcode            = opcode_reg;
  assign events.data.key_id            = key_reg;
  assign events.data.local_session_id  = local_session_reg;
  assign events.data.ack_count         = ack_count_reg;
  assign events.data.ack_id            = ack_shift_reg;
  assign events.data.remote_session_id = remote_session_reg;
  assign events.data.message_packet_id = message_id_reg;
  assign events.data.payload_byte      = payload_reg;
  assign events.data.last              = last_reg;

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_reg != EV_PAYLOAD) |-> payload_reg == 8'd0)
    else $error("payload byte nonzero outside a payload event");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_reg) |-> byte_position == '0)
    else $error("position not cleared after the last byte of a packet");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted byte produced no result");

  a_skip_only_rejected: assert property (@(posedge clk) disable iff (rst)
    (accept && ctl.ev == EV_SKIP) |-> rejected_flag)
    else $error("skip event on a packet that was not rejected");

endmodule

@@ tb/sv/vpn_control_packet_parser_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench for vpn_control_packet_parser_unit: drives control packet byte streams,
// predicts every result word and checks it field by field.
// Depends on vcpp_pkg, vcpp_in_if, vcpp_out_if and the parser top level.

module vpn_control_packet_parser_unit_tb import vcpp_pkg::*; ();

  localparam int LONG_HOLD = 60;
  localparam int FIXED_HDR = 1 + SESSION_BYTES + 1 + ID_BYTES;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic clk = 1'b0;
  logic rst;

  vcpp_in_if  bytes_if ();
  vcpp_out_if events_if ();

  vpn_control_packet_parser_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_if),
    .events (events_if)
  );

  always #5 clk = ~clk;

  vcpp_out_t expected_events[$];
  int        mismatches = 0;
  int        bytes_sent = 0;
  bit        sender_gap_on = 1'b1;
  bit        rx_stall_on = 1'b1;
  bit        long_hold_req = 1'b0;

  // Parser state as the stream has left it.
  logic [16:0] cur_pos;
  logic [15:0] cur_len;
  logic [4:0]  cur_opcode;
  logic [2:0]  cur_key;
  logic [63:0] cur_local;
  logic [7:0]  cur_acks;
  logic [31:0] cur_ack_word;
  logic [63:0] cur_remote;
  logic [31:0] cur_msg_id;
  logic        cur_short;

  function automatic void clear_fields();
    cur_len      = '0;
    cur_opcode   = '0;
    cur_key      = '0;
    cur_local    = '0;
    cur_acks     = '0;
    cur_ack_word = '0;
    cur_remote   = '0;
    cur_msg_id   = '0;
    cur_short    = 1'b0;
  endfunction

  function automatic vcpp_out_t parse_byte(input logic [7:0] b, input logic rs);
    int unsigned pos;
    int unsigned acks_end;
    int unsigned remote_end;
    int unsigned hdr_end;
    logic        ends;
    vcpp_out_t   r;
    r = '0;
    r.event_res = EV_HEADER;
    ends = 1'b0;
    if (rs) cur_pos = '0;
    pos = cur_pos;
    if (pos == 0) begin
      clear_fields();
      cur_len = {b, 8'h00};
    end else begin
      ends = (pos == cur_len + 1);
      if (pos == 1) begin
        cur_len[7:0] = b;
        ends = (cur_len == 0);
        if (cur_len < MIN_LENGTH) begin
          cur_short = 1'b1;
          r.event_res = EV_REJECT;
        end
      end else if (cur_short) begin
        r.event_res = EV_SKIP;
      end else begin
        acks_end = ACKS_BASE + ID_BYTES * cur_acks;
        remote_end = acks_end + ((cur_acks != 0) ? SESSION_BYTES : 0);
        hdr_end = remote_end + ID_BYTES;
        if (pos == LOCAL_START - 1) begin
          cur_opcode = b[7:KEY_BITS];
          cur_key = b[KEY_BITS-1:0];
        end else if (pos < ACK_COUNT_POS) begin
          cur_local = {cur_local[55:0], b};
        end else if (pos == ACK_COUNT_POS) begin
          cur_acks = b;
        end else if (pos < acks_end) begin
          cur_ack_word = {cur_ack_word[23:0], b};
          if ((pos - ACKS_BASE) % ID_BYTES == ID_BYTES - 1) r.event_res = EV_ACK_DONE;
        end else if (pos < remote_end) begin
          cur_remote = {cur_remote[55:0], b};
        end else if (pos < hdr_end) begin
          cur_msg_id = {cur_msg_id[23:0], b};
          if (pos == hdr_end - 1) r.event_res = EV_HDR_DONE;
        end else begin
          r.event_res = EV_PAYLOAD;
          r.payload_byte = b;
        end
        if (ends && pos + 1 < hdr_end) r.event_res = EV_TRUNC;
      end
    end
    cur_pos = ends ? '0 : 17'(pos + 1);
    r.packet_length     = cur_len;
    r.opcode            = cur_opcode;
    r.key_id            = cur_key;
    r.local_session_id  = cur_local;
    r.ack_count         = cur_acks;
    r.ack_id            = cur_ack_word;
    r.remote_session_id = cur_remote;
    r.message_packet_id = cur_msg_id;
    r.last              = ends;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    vcpp_out_t want;
    vcpp_out_t got;
    if (!rst && events_if.valid && events_if.ready) begin
      got = events_if.data;
      if (expected_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual event %0d", $time,
                 got.event_res);
      end else begin
        want = expected_events.pop_front();
        check_field("event_res", want.event_res, got.event_res);
        check_field("packet_length", want.packet_length, got.packet_length);
        check_field("opcode", want.opcode, got.opcode);
        check_field("key_id", want.key_id, got.key_id);
        check_field("local_session_id", want.local_session_id, got.local_session_id);
        check_field("ack_count", want.ack_count, got.ack_count);
        check_field("ack_id", want.ack_id, got.ack_id);
        check_field("remote_session_id", want.remote_session_id, got.remote_session_id);
        check_field("message_packet_id", want.message_packet_id, got.message_packet_id);
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("last", want.last, got.last);
      end
    end
  end

  // The result side stalls in short random bursts, or for one long counted stretch on request.
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    events_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        events_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        events_if.ready <= 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 5);
        events_if.ready <= 1'b0;
      end else begin
        events_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [7:0] fill_byte(input fill_t fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned natural_len(input int unsigned acks, input int unsigned pay);
    return FIXED_HDR + ID_BYTES * acks + ((acks != 0) ? SESSION_BYTES : 0) + pay;
  endfunction

  // Called right after a rising edge; returns at the edge that accepts the word.
  task automatic send_byte(input logic [7:0] b, input logic rs);
    if (sender_gap_on && $urandom_range(0, 9) == 0) begin
      bytes_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    bytes_if.valid <= 1'b1;
    bytes_if.data <= '{data_byte: b, restart: rs};
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
    expected_events.push_back(parse_byte(b, rs));
    bytes_sent++;
  endtask

  task automatic wait_drained();
    bytes_if.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  // Sends a packet with the given length prefix; the ack count byte carries acks.
  task automatic send_packet(input int unsigned len, input int unsigned acks,
                             input fill_t fill, input int cut = -1,
                             input logic rs_first = 1'b0, input int pause_at = -1);
    logic [7:0]  pkt[$];
    int unsigned total;
    total = (cut >= 0) ? cut : len + 2;
    pkt.push_back(len[15:8]);
    pkt.push_back(len[7:0]);
    while (pkt.size() < total)
      pkt.push_back((pkt.size() == ACK_COUNT_POS) ? acks[7:0] : fill_byte(fill));
    for (int i = 0; i < total; i++) begin
      if (i == pause_at) wait_drained();
      send_byte(pkt[i], (i == 0) ? rs_first : 1'b0);
    end
  endtask

  task automatic send_good_packet(input logic rs_first);
    int unsigned acks;
    acks = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
    send_packet(natural_len(acks, $urandom_range(0, 16)), acks, FILL_RANDOM, -1, rs_first);
  endtask

  task automatic test_short_packets();
    send_packet(0, 0, FILL_ZERO);
    send_packet(1, 0, FILL_ONES);
    send_packet(MIN_LENGTH - 1, 0, FILL_RANDOM);
  endtask

  task automatic test_header_extremes();
    send_packet(MIN_LENGTH, 0, FILL_ZERO);
    send_packet(MIN_LENGTH, 0, FILL_ONES);
    send_packet(natural_len(1, 3), 1, FILL_ONES);
    send_packet(natural_len(1, 2), 1, FILL_ZERO);
  endtask

  task automatic test_acks_and_payload();
    send_packet(natural_len(3, 8), 3, FILL_RANDOM);
    send_packet(natural_len(0, 5), 0, FILL_RANDOM);
  endtask

  task automatic test_truncated_header();
    send_packet(40, 255, FILL_ONES);
    send_packet(natural_len(1, 0) - 6, 1, FILL_RANDOM);
    send_packet(natural_len(1, 0) - 1, 1, FILL_RANDOM);
  endtask

  task automatic test_restart();
    send_packet(16'hFFFF, 1, FILL_RANDOM, 30);
    send_packet(natural_len(0, 2), 0, FILL_RANDOM, 7, 1'b1);
    send_packet(MIN_LENGTH - 1, 0, FILL_RANDOM, 6, 1'b1);
    send_packet(natural_len(2, 3), 2, FILL_RANDOM, -1, 1'b1);
  endtask

  task automatic test_result_backpressure();
    long_hold_req = 1'b1;
    send_packet(natural_len(2, 30), 2, FILL_RANDOM);
    wait_drained();
  endtask

  task automatic test_sender_pause();
    send_packet(natural_len(2, 6), 2, FILL_RANDOM, -1, 1'b0, 14);
  endtask

  // Mostly well-formed packets, with short, truncated, cut-off packets and loose bytes mixed in.
  task automatic test_random_stream(input int n_bytes);
    int          first;
    int unsigned acks;
    int unsigned len;
    int          kind;
    logic        need_restart;
    first = bytes_sent;
    need_restart = 1'b0;
    while (bytes_sent - first < n_bytes) begin
      sender_gap_on = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_good_packet(need_restart | 1'($urandom_range(0, 1)));
        need_restart = 1'b0;
      end else if (kind < 80) begin
        send_packet($urandom_range(0, MIN_LENGTH - 1), 0, FILL_RANDOM, -1,
                    need_restart | 1'($urandom_range(0, 1)));
        need_restart = 1'b0;
      end else if (kind < 88) begin
        acks = $urandom_range(1, 6);
        send_packet($urandom_range(MIN_LENGTH, natural_len(acks, 0) - 1), acks, FILL_RANDOM,
                    -1, need_restart);
        need_restart = 1'b0;
      end else if (kind < 94) begin
        acks = $urandom_range(0, 3);
        len = natural_len(acks, $urandom_range(0, 8));
        send_packet(len, acks, FILL_RANDOM, $urandom_range(1, len + 1), need_restart);
        need_restart = 1'b1;
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        need_restart = 1'b1;
      end
    end
    if (need_restart) send_good_packet(1'b1);
  endtask

  task automatic test_streaming_tail();
    sender_gap_on = 1'b0;
    rx_stall_on = 1'b0;
    repeat (4) send_good_packet(1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst <= 1'b1;
    bytes_if.valid <= 1'b0;
    bytes_if.data <= '0;
    cur_pos = '0;
    clear_fields();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_packets();
    test_header_extremes();
    test_acks_and_payload();
    test_truncated_header();
    test_restart();
    test_result_backpressure();
    test_sender_pause();
    test_random_stream(250);
    test_streaming_tail();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/vcpp_pkg.sv
hw/rtl/vcpp_in_if.sv
hw/rtl/vcpp_out_if.sv
hw/rtl/vcpp_decode.sv
hw/rtl/vpn_control_packet_parser_unit.sv
tb/sv/vpn_control_packet_parser_unit_tb.sv
